/* src/lppp_pkg.sv */
// ============================================================================
// lppp_pkg - shared types and constants of the lidar point projector
// Field widths, reject codes, register indexes and the inter-stage payloads.
// ============================================================================
package lppp_pkg;

    localparam int PIXEL_BITS_DEF = 12;

    localparam int PT_W   = 32;  // Q15.16 point coordinate
    localparam int EXT_W  = 16;  // Q3.12 extrinsic coefficient
    localparam int PROJ_W = 32;  // Q19.12 projection coefficient
    localparam int PROD_W = 48;  // extrinsic coefficient * coordinate
    localparam int ACC_W  = 51;  // camera coordinate sum, Q.28
    localparam int CAM_W  = 39;  // camera coordinate, Q.16
    localparam int NUM_W  = 55;  // |camera coordinate| << 16
    localparam int QUO_W  = 31;  // saturated normalized coordinate, Q.16
    localparam int DIV_LAT = QUO_W + 1;
    localparam int PM_W   = 63;  // projection coefficient * normalized coordinate
    localparam int SUM_W  = 66;  // projection sum, Q.28
    localparam int MAG_W  = SUM_W - 28;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_EXT0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXT1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXT2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_P0_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_P0_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_P1_LEFT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_P1_RIGHT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_SIZE  = 3'd7;

    localparam logic [1:0] RSN_OK    = 2'd0;
    localparam logic [1:0] RSN_X     = 2'd1;
    localparam logic [1:0] RSN_DEPTH = 2'd2;
    localparam logic [1:0] RSN_OUT   = 2'd3;

    typedef struct packed {
        logic [2:0][63:0]      ext;   // [row], column 0 in low bits
        logic [1:0][1:0][63:0] proj;  // [row][0 = left, 1 = right]
        logic [31:0]           size;  // height 31:16, width 15:0
    } t_cfg;

    typedef struct packed {
        logic [1:0]              reason;
        logic signed [CAM_W-1:0] cx;
        logic signed [CAM_W-1:0] cy;
        logic signed [CAM_W-1:0] cz;
    } t_mid;

endpackage

/* src/lppp_fifo.sv */
// ============================================================================
// lppp_fifo - small register queue
// First-word-fall-through queue; push only when not full.
// ============================================================================
module lppp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp, n_wp, n_rp;
    logic [AW:0]      r_cnt, n_cnt;
    logic             w_push, w_pop;

    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_rp  = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= n_wp;
            if (w_pop)  r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* src/lppp_front.sv */
// ============================================================================
// lppp_front - point intake and extrinsic transform
// Three stages: capture, 16x32 products, sum / floor / classify.
// ============================================================================
module lppp_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lppp_pkg::t_cfg                     i_cfg,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic signed [lppp_pkg::PT_W-1:0]   i_x,
    input  logic signed [lppp_pkg::PT_W-1:0]   i_y,
    input  logic signed [lppp_pkg::PT_W-1:0]   i_z,
    output logic                               o_mid_push,
    output lppp_pkg::t_mid                     o_mid,
    input  logic                               i_mid_full
);
    import lppp_pkg::*;

    logic                     w_en;
    logic signed [EXT_W-1:0]  w_coef [3][4];

    logic                     r_v1, r_v2, r_v3;
    logic signed [PT_W-1:0]   r_x1, r_y1, r_z1;
    logic                     r_xbad2;
    logic signed [PROD_W-1:0] r_p [3][3];
    logic signed [PROD_W-1:0] r_k [3];
    t_mid                     r_mid3;

    logic signed [ACC_W-1:0]  w_acc [3];
    logic signed [CAM_W-1:0]  w_cam [3];

    assign w_en       = !r_v3 || !i_mid_full;
    assign o_full     = !w_en;
    assign o_mid_push = r_v3 && !i_mid_full;
    assign o_mid      = r_mid3;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                w_coef[r][c] = i_cfg.ext[r][EXT_W*c +: EXT_W];
            end
        end
    end

    // floor to Q.16 is an arithmetic shift of the Q.28 sum
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_acc[r] = ACC_W'(r_p[r][0]) + ACC_W'(r_p[r][1])
                     + ACC_W'(r_p[r][2]) + ACC_W'(r_k[r]);
            w_cam[r] = w_acc[r][ACC_W-1:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x1 <= i_x;
            r_y1 <= i_y;
            r_z1 <= i_z;

            r_xbad2 <= (r_x1 <= 0);
            for (int r = 0; r < 3; r++) begin
                r_p[r][0] <= w_coef[r][0] * r_x1;
                r_p[r][1] <= w_coef[r][1] * r_y1;
                r_p[r][2] <= w_coef[r][2] * r_z1;
                r_k[r]    <= {{(PROD_W-2*EXT_W){w_coef[r][3][EXT_W-1]}},
                              w_coef[r][3], 16'h0000};
            end

            r_mid3.cx <= w_cam[0];
            r_mid3.cy <= w_cam[1];
            r_mid3.cz <= w_cam[2];
            if (r_xbad2) begin
                r_mid3.reason <= RSN_X;
            end else if (w_cam[2] <= 0) begin
                r_mid3.reason <= RSN_DEPTH;
            end else begin
                r_mid3.reason <= RSN_OK;
            end
        end
    end

endmodule

/* src/lppp_div.sv */
// ============================================================================
// lppp_div - pipelined saturating divider
// q = trunc((n << 16) / d) clamped to [-2^30, 2^30-1]; one quotient bit a stage.
// ============================================================================
module lppp_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [lppp_pkg::CAM_W-1:0]   i_num,
    input  logic signed [lppp_pkg::CAM_W-1:0]   i_den,
    output logic signed [lppp_pkg::QUO_W-1:0]   o_quo
);
    import lppp_pkg::*;

    localparam int CMP_W = CAM_W + QUO_W;

    logic [NUM_W-1:0] r_rem [QUO_W+1];
    logic [CAM_W-1:0] r_den [QUO_W+1];
    logic [QUO_W-1:0] r_q   [QUO_W+1];
    logic             r_neg [QUO_W+1];
    logic             r_ovf [QUO_W+1];

    logic [CAM_W-1:0] w_mag;
    logic [NUM_W-1:0] w_n;

    assign w_mag = i_num[CAM_W-1] ? CAM_W'(-i_num) : CAM_W'(i_num);
    assign w_n   = {w_mag, 16'h0000};

    // entry: magnitude and overflow check (quotient >= 2^31 saturates)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_n;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_num[CAM_W-1];
            r_ovf[0] <= ({{(CMP_W-NUM_W){1'b0}}, w_n} >= {i_den, {QUO_W{1'b0}}});
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - k;
        logic [CMP_W-1:0] w_sh;
        logic             w_ge;
        assign w_sh = {{QUO_W{1'b0}}, r_den[k-1]} << BIT;
        assign w_ge = ({{(CMP_W-NUM_W){1'b0}}, r_rem[k-1]} >= w_sh);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? r_rem[k-1] - w_sh[NUM_W-1:0] : r_rem[k-1];
                r_q[k]   <= r_q[k-1] | (w_ge ? (QUO_W'(1) << BIT) : '0);
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    localparam logic [QUO_W-1:0] SAT_POS = {1'b0, {(QUO_W-1){1'b1}}};
    localparam logic [QUO_W-1:0] SAT_NEG = {1'b1, {(QUO_W-1){1'b0}}};

    always_comb begin
        if (r_ovf[QUO_W]) begin
            o_quo = r_neg[QUO_W] ? SAT_NEG : SAT_POS;
        end else if (!r_neg[QUO_W]) begin
            o_quo = r_q[QUO_W][QUO_W-1] ? SAT_POS : r_q[QUO_W];
        end else if (r_q[QUO_W][QUO_W-1] && (|r_q[QUO_W][QUO_W-2:0])) begin
            o_quo = SAT_NEG;
        end else begin
            o_quo = -r_q[QUO_W];
        end
    end

endmodule

/* src/lppp_back.sv */
// ============================================================================
// lppp_back - normalization, projection, rounding and image test
// Divider stages, then products, sum, round and classify; stalls on output.
// ============================================================================
module lppp_back #(
    parameter int PIXEL_BITS = lppp_pkg::PIXEL_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lppp_pkg::t_cfg        i_cfg,
    input  logic                  i_mid_empty,
    output logic                  o_mid_pop,
    input  lppp_pkg::t_mid        i_mid,
    output logic                  o_out_push,
    input  logic                  i_out_full,
    output logic                  o_visible,
    output logic [PIXEL_BITS-1:0] o_col,
    output logic [PIXEL_BITS-1:0] o_row,
    output logic [1:0]            o_reason
);
    import lppp_pkg::*;

    localparam int NST = DIV_LAT + 4;
    localparam int B3 = DIV_LAT + 2;

    logic                     w_en;
    logic                     r_v   [NST];
    logic [1:0]               r_rsn [NST];
    logic signed [QUO_W-1:0]  w_uv  [2];

    logic signed [PM_W-1:0]   r_m   [2][2];
    logic signed [PROJ_W:0]   w_ksum [2];
    logic signed [SUM_W-1:0]  r_k   [2];
    logic signed [SUM_W-1:0]  r_s   [2];
    logic [SUM_W-1:0]         w_abs [2];
    logic [SUM_W-1:0]         w_rnd [2];
    logic                     r_neg [2];
    logic [MAG_W-1:0]         r_mag [2];
    logic                     w_out [2];
    logic [MAG_W-1:0]         w_lim [2];

    assign w_en       = !r_v[NST-1] || !i_out_full;
    assign o_mid_pop  = w_en && !i_mid_empty;
    assign o_out_push = r_v[NST-1] && !i_out_full;

    lppp_div u_div_u (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (i_mid.cx),
        .i_den (i_mid.cz),
        .o_quo (w_uv[0])
    );

    lppp_div u_div_v (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (i_mid.cy),
        .i_den (i_mid.cz),
        .o_quo (w_uv[1])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NST; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= !i_mid_empty;
            for (int k = 1; k < NST; k++) r_v[k] <= r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rsn[0] <= i_mid.reason;
            for (int k = 1; k < NST; k++) r_rsn[k] <= r_rsn[k-1];
        end
    end

    // width / height limits
    assign w_lim[0] = MAG_W'(i_cfg.size[15:0]);
    assign w_lim[1] = MAG_W'(i_cfg.size[31:16]);

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            w_ksum[r] = (PROJ_W+1)'($signed(i_cfg.proj[r][1][31:0]))
                      + (PROJ_W+1)'($signed(i_cfg.proj[r][1][63:32]));
            w_abs[r]  = r_s[r][SUM_W-1] ? SUM_W'(-r_s[r]) : SUM_W'(r_s[r]);
            w_rnd[r]  = w_abs[r] + (SUM_W'(1) << 27);
            w_out[r]  = (r_neg[r] && (r_mag[r] != '0)) || (r_mag[r] >= w_lim[r])
                      || (r_mag[r] >= (MAG_W'(1) << PIXEL_BITS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int r = 0; r < 2; r++) begin
                // B1: products
                r_m[r][0] <= $signed(i_cfg.proj[r][0][31:0])  * w_uv[0];
                r_m[r][1] <= $signed(i_cfg.proj[r][0][63:32]) * w_uv[1];
                r_k[r]    <= SUM_W'(w_ksum[r]) <<< 16;
                // B2: Q.28 sum
                r_s[r]    <= SUM_W'(r_m[r][0]) + SUM_W'(r_m[r][1]) + r_k[r];
                // B3: round half away from zero, keep sign and magnitude
                r_neg[r]  <= r_s[r][SUM_W-1];
                r_mag[r]  <= w_rnd[r][SUM_W-1:28];
            end
            // B4: classify
            if (r_rsn[B3] != RSN_OK) begin
                o_visible <= 1'b0;
                o_col     <= '0;
                o_row     <= '0;
                o_reason  <= r_rsn[B3];
            end else if (w_out[0] || w_out[1]) begin
                o_visible <= 1'b0;
                o_col     <= '0;
                o_row     <= '0;
                o_reason  <= RSN_OUT;
            end else begin
                o_visible <= 1'b1;
                o_col     <= r_mag[0][PIXEL_BITS-1:0];
                o_row     <= r_mag[1][PIXEL_BITS-1:0];
                o_reason  <= RSN_OK;
            end
        end
    end

endmodule

/* src/lidar_point_to_pixel_projector.sv */
// ============================================================================
// lidar_point_to_pixel_projector - lidar point to camera pixel projection
// Extrinsic transform, depth divide, pinhole projection and image test.
// ============================================================================
// Usage:
//  - Input queue: drive i_point_x/y/z and raise push; a request is taken at
//    a rising edge with push high and full low. One request per cycle.
//  - Result queue: while empty is low the oldest result sits on o_visible,
//    o_pixel_col, o_pixel_row and o_reject_reason; pop takes it.
//  - Config: i_cfg_we with i_cfg_idx (0..7, in register order) and
//    i_cfg_data writes one register at the clock edge. Write only while idle.
//  - Pipeline: 41 register stages (3 front, 1 mid queue, 32 divider, 4
//    projection, 1 output queue), the first loaded at the accepting edge.
//  - Throughput: one point per cycle unless the receiver stalls, set by the
//    one-bit-per-stage divider and multiplier stages, all fully pipelined.
//  - A rejected point still yields one result, with zero pixel and a reason.
//  - Reset (synchronous, active low) clears the valid bits, queue pointers
//    and configuration registers, and empties both pipelines and queues.
//  - When the receiver stalls the back pipeline holds, the mid queue fills,
//    and then the front holds and raises full; nothing is dropped.
// ============================================================================
module lidar_point_to_pixel_projector #(
    parameter int PIXEL_BITS = lppp_pkg::PIXEL_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [lppp_pkg::PT_W-1:0]       i_point_x,
    input  logic signed [lppp_pkg::PT_W-1:0]       i_point_y,
    input  logic signed [lppp_pkg::PT_W-1:0]       i_point_z,
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   o_visible,
    output logic [PIXEL_BITS-1:0]                  o_pixel_col,
    output logic [PIXEL_BITS-1:0]                  o_pixel_row,
    output logic [1:0]                             o_reject_reason,
    input  logic                                   i_cfg_we,
    input  logic [lppp_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [lppp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import lppp_pkg::*;

    localparam int MID_W   = $bits(t_mid);
    localparam int OUT_W   = 1 + 2 * PIXEL_BITS + 2;
    localparam int MID_DEP = 4;
    localparam int OUT_DEP = 2;

    t_cfg             r_cfg;

    logic             w_mid_push, w_mid_full, w_mid_pop, w_mid_empty;
    t_mid             w_mid_in;
    logic [MID_W-1:0] w_mid_bits;

    logic             w_out_push, w_out_full;
    logic             w_b_vis;
    logic [PIXEL_BITS-1:0] w_b_col, w_b_row;
    logic [1:0]       w_b_rsn;
    logic [OUT_W-1:0] w_out_bits;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EXT0:     r_cfg.ext[0]     <= i_cfg_data;
                REG_EXT1:     r_cfg.ext[1]     <= i_cfg_data;
                REG_EXT2:     r_cfg.ext[2]     <= i_cfg_data;
                REG_P0_LEFT:  r_cfg.proj[0][0] <= i_cfg_data;
                REG_P0_RIGHT: r_cfg.proj[0][1] <= i_cfg_data;
                REG_P1_LEFT:  r_cfg.proj[1][0] <= i_cfg_data;
                REG_P1_RIGHT: r_cfg.proj[1][1] <= i_cfg_data;
                REG_IMG_SIZE: r_cfg.size       <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    lppp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_push     (push),
        .o_full     (full),
        .i_x        (i_point_x),
        .i_y        (i_point_y),
        .i_z        (i_point_z),
        .o_mid_push (w_mid_push),
        .o_mid      (w_mid_in),
        .i_mid_full (w_mid_full)
    );

    // decoupling queue between front and back
    lppp_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEP)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_mid_push),
        .i_data  (w_mid_in),
        .o_full  (w_mid_full),
        .i_pop   (w_mid_pop),
        .o_data  (w_mid_bits),
        .o_empty (w_mid_empty)
    );

    lppp_back #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .i_mid       (t_mid'(w_mid_bits)),
        .o_out_push  (w_out_push),
        .i_out_full  (w_out_full),
        .o_visible   (w_b_vis),
        .o_col       (w_b_col),
        .o_row       (w_b_row),
        .o_reason    (w_b_rsn)
    );

    // result queue: parts the back pipeline from the receiver
    lppp_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEP)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  ({w_b_vis, w_b_col, w_b_row, w_b_rsn}),
        .o_full  (w_out_full),
        .i_pop   (pop),
        .o_data  (w_out_bits),
        .o_empty (empty)
    );

    assign {o_visible, o_pixel_col, o_pixel_row, o_reject_reason} = w_out_bits;

endmodule
